// ===== design/esr_pkg.sv =====
`timescale 1ns / 1ps

package esr_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);

  typedef logic [2:0] sym_t;

  localparam sym_t SYM_E     = 3'd0;
  localparam sym_t SYM_PLUS  = 3'd1;
  localparam sym_t SYM_STAR  = 3'd2;
  localparam sym_t SYM_OPEN  = 3'd3;
  localparam sym_t SYM_CLOSE = 3'd4;
  localparam sym_t SYM_OTHER = 3'd5;

  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_STAR  = 8'h2a;
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    sym_t              wdata;
    logic [ADDR_W-1:0] raddr1;
    logic [ADDR_W-1:0] raddr2;
  } stack_req_t;

  function automatic sym_t encode(input logic [7:0] ch);
    sym_t s;
    case (ch)
      CH_A:     s = SYM_E;
      CH_PLUS:  s = SYM_PLUS;
      CH_STAR:  s = SYM_STAR;
      CH_OPEN:  s = SYM_OPEN;
      CH_CLOSE: s = SYM_CLOSE;
      default:  s = SYM_OTHER;
    endcase
    return s;
  endfunction

endpackage

// ===== design/esr_stack.sv =====
`timescale 1ns / 1ps

module esr_stack import esr_pkg::*; (
  input  logic       clk,
  input  stack_req_t req,
  output sym_t       rdata1,
  output sym_t       rdata2
);

  sym_t mem [STACK_DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata1 <= mem[req.raddr1];
    rdata2 <= mem[req.raddr2];
  end

endmodule

// ===== design/esr_match.sv =====
`timescale 1ns / 1ps

module esr_match import esr_pkg::*; (
  input  logic enable,
  input  sym_t x,
  input  sym_t y,
  input  sym_t z,
  output logic hit
);

  logic binop;
  logic paren;

  // x is the deepest of the three, z the top
  assign binop = (x == SYM_E) && ((y == SYM_STAR) || (y == SYM_PLUS)) && (z == SYM_E);
  assign paren = (x == SYM_OPEN) && (y == SYM_E) && (z == SYM_CLOSE);
  assign hit   = enable && (binop || paren);

endmodule

// ===== design/expression_shift_reduce_recognizer.sv =====
`timescale 1ns / 1ps

// channel   handshake             payload
// input     in_valid / in_ready   symbol[7:0], last
// output    out_valid / out_ready depth[4:0], reductions[3:0], done_res, accepted, overflow
//
// an item passes the read and check steps after accept, and again for each pattern
// reduction (a to E needs none); the done step loads the result and then ready returns
// a push onto a full stack skips the read and reduce loop and goes to the done step
// each reduction is one registered stack read and one pass of the shared compare
// synchronous reset clears stack pointer, overflow flag and handshake state, not the stack
// a stalled result holds the block in its final step until the output register is free

module expression_shift_reduce_recognizer import esr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] symbol,
  input  logic       last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [4:0] depth,
  output logic [3:0] reductions,
  output logic       done_res,
  output logic       accepted,
  output logic       overflow
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_READ  = 2'd1;
  localparam logic [1:0] S_CHECK = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0]         state;
  logic [DEPTH_W-1:0] sp;
  logic               ovf;
  sym_t               top;
  logic [3:0]         cnt;
  logic               last_q;

  stack_req_t         req;
  sym_t               rd1;
  sym_t               rd2;
  logic               hit;
  logic               full;
  logic               in_fire;
  logic               out_load;
  logic [DEPTH_W-1:0] sp_m2;
  logic [DEPTH_W-1:0] sp_m3;
  logic [3:0]         cnt_inc;

  assign full     = (sp >= DEPTH_W'(STACK_DEPTH));
  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_load = (state == S_DONE) && (!out_valid || out_ready);
  assign sp_m2    = sp - DEPTH_W'(2);
  assign sp_m3    = sp - DEPTH_W'(3);
  assign cnt_inc  = (cnt == 4'hf) ? cnt : cnt + 4'd1;

  always_comb begin
    req.raddr1 = sp_m2[ADDR_W-1:0];
    req.raddr2 = sp_m3[ADDR_W-1:0];
    req.we     = 1'b0;
    req.waddr  = sp[ADDR_W-1:0];
    req.wdata  = encode(symbol);
    if (in_fire && !full) begin
      req.we = 1'b1;
    end else if ((state == S_CHECK) && hit) begin
      req.we    = 1'b1;
      req.waddr = sp_m3[ADDR_W-1:0];
      req.wdata = SYM_E;
    end
  end

  esr_stack u_stack (
    .clk    (clk),
    .req    (req),
    .rdata1 (rd1),
    .rdata2 (rd2)
  );

  esr_match u_match (
    .enable (sp >= DEPTH_W'(3)),
    .x      (rd2),
    .y      (rd1),
    .z      (top),
    .hit    (hit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      sp        <= '0;
      ovf       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            last_q <= last;
            if (full) begin
              ovf   <= 1'b1;
              cnt   <= 4'd0;
              state <= S_DONE;
            end else begin
              top   <= encode(symbol);
              sp    <= sp + DEPTH_W'(1);
              cnt   <= (symbol == CH_A) ? 4'd1 : 4'd0;
              state <= S_READ;
            end
          end
        end
        S_READ: begin
          state <= S_CHECK;
        end
        S_CHECK: begin
          if (hit) begin
            top   <= SYM_E;
            sp    <= sp_m2;
            cnt   <= cnt_inc;
            state <= S_READ;
          end else begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_load) begin
            if (last_q) begin
              sp  <= '0;
              ovf <= 1'b0;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // with one entry left, the top register holds the bottom of the stack
  always_ff @(posedge clk) begin
    if (out_load) begin
      depth      <= 5'(sp);
      reductions <= cnt;
      done_res   <= last_q;
      accepted   <= last_q && (sp == DEPTH_W'(1)) && (top == SYM_E) && !ovf;
      overflow   <= ovf;
    end
  end

endmodule

// ===== design/esr_checker.sv =====
`timescale 1ns / 1ps

module esr_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [4:0] depth,
  input logic [3:0] reductions,
  input logic       done_res,
  input logic       accepted,
  input logic       overflow
);

  // a held result keeps its depth, reductions and accepted fields
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(depth) && $stable(reductions)
      && $stable(accepted))
    else $error("stalled result changed");

  // one request at a time
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("ready stayed high after a request");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && accepted |-> done_res && !overflow)
    else $error("accept without end of string or with overflow");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && accepted |-> depth == 5'd1)
    else $error("accept with depth other than one");

endmodule

bind expression_shift_reduce_recognizer esr_checker u_esr_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .depth      (depth),
  .reductions (reductions),
  .done_res   (done_res),
  .accepted   (accepted),
  .overflow   (overflow)
);

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import esr_pkg::*;

  localparam int TARGET_ITEMS = 1250;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic [4:0] depth;
    logic [3:0] reductions;
    logic       done_res;
    logic       accepted;
    logic       overflow;
  } parse_result_t;

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       in_valid  = 1'b0;
  logic       in_ready;
  logic [7:0] symbol    = 8'h00;
  logic       last      = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [4:0] depth;
  logic [3:0] reductions;
  logic       done_res;
  logic       accepted;
  logic       overflow;

  // shadow of the parser state
  sym_t          sym_stack [STACK_DEPTH];
  int unsigned   stack_ptr     = 0;
  logic          overflow_seen = 1'b0;

  parse_result_t pending_results [$];
  logic [7:0]    text [$];
  int            items_sent     = 0;
  int            mismatch_count = 0;
  bit            no_idle        = 1'b0;
  bit            hold_request   = 1'b0;

  expression_shift_reduce_recognizer dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .symbol     (symbol),
    .last       (last),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .depth      (depth),
    .reductions (reductions),
    .done_res   (done_res),
    .accepted   (accepted),
    .overflow   (overflow)
  );

  always #5 clk = ~clk;

  initial begin
    #3_000_000;
    $display("Some tests failed");
    $finish;
  end

  function automatic sym_t symbol_class(input logic [7:0] ch);
    sym_t s;
    case (ch)
      CH_A:     s = SYM_E;
      CH_PLUS:  s = SYM_PLUS;
      CH_STAR:  s = SYM_STAR;
      CH_OPEN:  s = SYM_OPEN;
      CH_CLOSE: s = SYM_CLOSE;
      default:  s = SYM_OTHER;
    endcase
    return s;
  endfunction

  function automatic parse_result_t shift_and_reduce(input logic [7:0] ch, input logic fin);
    parse_result_t r;
    int unsigned   count;
    bit            matched;
    sym_t          x, y, z;
    count = 0;
    if (stack_ptr >= STACK_DEPTH) begin
      // push dropped, stack untouched
      overflow_seen = 1'b1;
    end else begin
      sym_stack[ADDR_W'(stack_ptr)] = symbol_class(ch);
      stack_ptr++;
      if (ch == CH_A) count++;
      do begin
        matched = 1'b0;
        if (stack_ptr >= 3) begin
          x = sym_stack[ADDR_W'(stack_ptr - 3)];
          y = sym_stack[ADDR_W'(stack_ptr - 2)];
          z = sym_stack[ADDR_W'(stack_ptr - 1)];
          if ((x == SYM_E && (y == SYM_STAR || y == SYM_PLUS) && z == SYM_E) ||
              (x == SYM_OPEN && y == SYM_E && z == SYM_CLOSE)) begin
            sym_stack[ADDR_W'(stack_ptr - 3)] = SYM_E;
            stack_ptr -= 2;
            count++;
            matched = 1'b1;
          end
        end
      end while (matched);
    end
    r.depth      = 5'(stack_ptr);
    r.reductions = (count > 15) ? 4'd15 : 4'(count);
    r.done_res   = fin;
    r.overflow   = overflow_seen;
    r.accepted   = fin && stack_ptr == 1 && sym_stack[0] == SYM_E && !overflow_seen;
    if (fin) begin
      stack_ptr     = 0;
      overflow_seen = 1'b0;
    end
    return r;
  endfunction

  task automatic send_request(input logic [7:0] ch, input logic fin);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    symbol   <= ch;
    last     <= fin;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(shift_and_reduce(ch, fin));
    items_sent++;
  endtask

  task automatic send_string();
    for (int i = 0; i < text.size(); i++)
      send_request(text[i], i == text.size() - 1);
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic void build_expr(input int level);
    int pick;
    pick = (level <= 0) ? 0 : $urandom_range(0, 3);
    case (pick)
      0: text.push_back(CH_A);
      1: begin
        build_expr(level - 1);
        text.push_back(CH_PLUS);
        build_expr(level - 1);
      end
      2: begin
        build_expr(level - 1);
        text.push_back(CH_STAR);
        build_expr(level - 1);
      end
      default: begin
        text.push_back(CH_OPEN);
        build_expr(level - 1);
        text.push_back(CH_CLOSE);
      end
    endcase
  endfunction

  function automatic void make_random_string();
    int kind;
    int idx;
    int n;
    text.delete();
    kind = $urandom_range(0, 99);
    if (kind < 75) begin
      build_expr($urandom_range(0, 4));
    end else if (kind < 87) begin
      // broken expression: one character corrupted or dropped
      build_expr($urandom_range(1, 3));
      idx = $urandom_range(0, text.size() - 1);
      if ($urandom_range(0, 1) == 1 || text.size() < 2)
        text[idx] = 8'($urandom_range(0, 255));
      else
        text.delete(idx);
    end else if (kind < 95) begin
      n = $urandom_range(1, 8);
      repeat (n) text.push_back(8'($urandom_range(0, 255)));
    end else begin
      // deep nesting, some of these run past the stack
      n = $urandom_range(14, 20);
      repeat (n) text.push_back(CH_OPEN);
      build_expr(1);
      repeat (n) text.push_back(CH_CLOSE);
    end
  endfunction

  task automatic compare_field(input string name, input int unsigned want_v,
                               input int unsigned got_v);
    if (want_v != got_v) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want_v, got_v);
      mismatch_count++;
    end
  endtask

  task automatic check_result();
    parse_result_t want;
    if (pending_results.size() == 0) begin
      $display("%0t: unexpected result, expected none actual depth %0d reductions %0d done %0b",
               $time, depth, reductions, done_res);
      mismatch_count++;
    end else begin
      want = pending_results.pop_front();
      compare_field("depth", 32'(want.depth), 32'(depth));
      compare_field("reductions", 32'(want.reductions), 32'(reductions));
      compare_field("done_res", 32'(want.done_res), 32'(done_res));
      compare_field("accepted", 32'(want.accepted), 32'(accepted));
      compare_field("overflow", 32'(want.overflow), 32'(overflow));
    end
  endtask

  initial begin : result_sink
    int stall;
    wait (!rst);
    @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        stall = HOLD_CYCLES;
      end else begin
        stall = no_idle ? 0 : $urandom_range(0, 9);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      check_result();
    end
  end

  task automatic test_grammar_rules();
    text.delete();
    text.push_back(CH_A);
    send_string();
    // product, then a parenthesized term that chains into the sum
    text.delete();
    text.push_back(CH_A);
    text.push_back(CH_STAR);
    text.push_back(CH_A);
    text.push_back(CH_PLUS);
    text.push_back(CH_OPEN);
    text.push_back(CH_A);
    text.push_back(CH_CLOSE);
    send_string();
  endtask

  task automatic test_unknown_bytes();
    text.delete();
    text.push_back(8'hff);
    text.push_back(8'h00);
    send_string();
  endtask

  task automatic test_stack_overflow();
    text.delete();
    repeat (STACK_DEPTH) text.push_back(CH_OPEN);
    text.push_back(CH_A);
    send_string();
    // flag must be gone for the next string
    text.delete();
    text.push_back(CH_A);
    send_string();
  endtask

  task automatic test_back_to_back();
    no_idle = 1'b1;
    repeat (8) begin
      make_random_string();
      send_string();
    end
    no_idle = 1'b0;
  endtask

  task automatic test_output_backpressure();
    int start_count;
    start_count  = items_sent;
    hold_request = 1'b1;
    while (items_sent - start_count < 40) begin
      make_random_string();
      send_string();
    end
  endtask

  task automatic test_drain_pause();
    repeat (3) begin
      make_random_string();
      send_string();
    end
    wait_for_drain();
    repeat (3) begin
      make_random_string();
      send_string();
    end
  endtask

  task automatic test_random_strings();
    while (items_sent < TARGET_ITEMS) begin
      make_random_string();
      send_string();
    end
  endtask

  initial begin : stimulus
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_grammar_rules();
    test_unknown_bytes();
    test_stack_overflow();
    test_back_to_back();
    test_output_backpressure();
    test_drain_pause();
    test_random_strings();
    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
